### sv/pid_position_and_increment_top_macros.svh
// Assertion macros for the PID block
`ifndef PID_POSITION_AND_INCREMENT_TOP_MACROS_SVH
`define PID_POSITION_AND_INCREMENT_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PIDPI_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("pidpi: same-cycle check failed");

// next-cycle implication
`define PIDPI_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("pidpi: next-cycle check failed");

`else

`define PIDPI_ASSERT_SAME(label, clk, rst_n, cond, expr)
`define PIDPI_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

### sv/pidpi_pkg.sv
package pidpi_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned ERR_W  = 17;
    localparam int unsigned OP_W   = 19;
    localparam int unsigned PROD_W = DATA_W + OP_W;
    localparam int unsigned SUM_W  = PROD_W + 2;
    localparam int unsigned DRIVE_W = 32;
    localparam int unsigned IDX_W  = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE     = 3'd0,
        REG_KP       = 3'd1,
        REG_KI       = 3'd2,
        REG_KD       = 3'd3,
        REG_SETPOINT = 3'd4
    } reg_idx_t;

    typedef enum logic {
        MODE_POSITIONAL  = 1'b0,
        MODE_INCREMENTAL = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [DATA_W-1:0]  kp;
        logic signed [DATA_W-1:0]  ki;
        logic signed [DATA_W-1:0]  kd;
        logic signed [DATA_W-1:0]  setpoint;
    } cfg_t;

    typedef struct packed {
        mode_t                  mode;
        logic signed [OP_W-1:0] a_p;
        logic signed [OP_W-1:0] a_i;
        logic signed [OP_W-1:0] a_d;
    } ops_t;

    typedef struct packed {
        mode_t                    mode;
        logic signed [PROD_W-1:0] p_p;
        logic signed [PROD_W-1:0] p_i;
        logic signed [PROD_W-1:0] p_d;
    } prods_t;

    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic out_load;
    } adv_t;

endpackage

### sv/pidpi_front.sv
module pidpi_front #(
    parameter int INTEGRAL_LIMIT = 4000
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic signed [pidpi_pkg::DATA_W-1:0]  measured,
    input  pidpi_pkg::cfg_t                      cfg,
    output pidpi_pkg::ops_t                      ops
);

    localparam int IW = $clog2(INTEGRAL_LIMIT + 1) + 1;
    localparam logic signed [17:0] ILIM_POS = 18'(INTEGRAL_LIMIT);
    localparam logic signed [17:0] ILIM_NEG = -18'(INTEGRAL_LIMIT);

    logic signed [IW-1:0]                   integral_reg;
    logic signed [IW-1:0]                   integral_next;
    logic signed [pidpi_pkg::ERR_W-1:0]     last_err_reg;
    logic signed [pidpi_pkg::ERR_W-1:0]     prior_err_reg;
    pidpi_pkg::ops_t                        ops_reg;
    pidpi_pkg::ops_t                        ops_next;

    logic signed [pidpi_pkg::ERR_W-1:0]     err;
    logic signed [17:0]                     isum;
    logic signed [17:0]                     isum_clamped;
    logic signed [17:0]                     diff1;
    logic signed [18:0]                     diff2;

    always_comb
    begin
        err  = {cfg.setpoint[15], cfg.setpoint} - {measured[15], measured};
        isum = {{(18-IW){integral_reg[IW-1]}}, integral_reg} + {err[16], err};
        if (isum > ILIM_POS)
        begin
            isum_clamped = ILIM_POS;
        end
        else if (isum < ILIM_NEG)
        begin
            isum_clamped = ILIM_NEG;
        end
        else
        begin
            isum_clamped = isum;
        end
        integral_next = isum_clamped[IW-1:0];
        diff1 = {err[16], err} - {last_err_reg[16], last_err_reg};
        diff2 = {{2{err[16]}}, err} - {last_err_reg[16], last_err_reg, 1'b0}
              + {{2{prior_err_reg[16]}}, prior_err_reg};

        ops_next.mode = cfg.mode;
        if (cfg.mode == pidpi_pkg::MODE_POSITIONAL)
        begin
            ops_next.a_p = {{2{err[16]}}, err};
            ops_next.a_i = {isum_clamped[17], isum_clamped};
            ops_next.a_d = {diff1[17], diff1};
        end
        else
        begin
            ops_next.a_p = {diff1[17], diff1};
            ops_next.a_i = {{2{err[16]}}, err};
            ops_next.a_d = diff2;
        end
    end

    // error history and integral advance only when an item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg  <= '0;
            last_err_reg  <= '0;
            prior_err_reg <= '0;
        end
        else if (load)
        begin
            last_err_reg <= err;
            if (cfg.mode == pidpi_pkg::MODE_POSITIONAL)
            begin
                integral_reg <= integral_next;
            end
            else
            begin
                prior_err_reg <= last_err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ops_reg <= ops_next;
        end
    end

    assign ops = ops_reg;

endmodule

### sv/pidpi_mult.sv
module pidpi_mult (
    input  logic                clk,
    input  logic                load,
    input  pidpi_pkg::cfg_t     cfg,
    input  pidpi_pkg::ops_t     ops,
    output pidpi_pkg::prods_t   prods
);

    pidpi_pkg::prods_t prods_reg;
    pidpi_pkg::prods_t prods_next;

    always_comb
    begin
        prods_next.mode = ops.mode;
        prods_next.p_p  = cfg.kp * ops.a_p;
        prods_next.p_i  = cfg.ki * ops.a_i;
        prods_next.p_d  = cfg.kd * ops.a_d;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prods_reg <= prods_next;
        end
    end

    assign prods = prods_reg;

endmodule

### sv/pidpi_back.sv
module pidpi_back #(
    parameter int OUTPUT_LIMIT   = 16384,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   load,
    input  pidpi_pkg::prods_t                      prods,
    output logic signed [pidpi_pkg::DRIVE_W-1:0]   drive
);

    localparam int SW = pidpi_pkg::SUM_W;
    localparam int PW = pidpi_pkg::PROD_W;
    localparam int DW = pidpi_pkg::DRIVE_W;
    localparam int AW = $clog2(OUTPUT_LIMIT + 1) + 1;
    localparam logic signed [SW-1:0] FRAC_BIAS = (SW'(1) << GAIN_FRAC_BITS) - SW'(1);
    localparam logic signed [SW-1:0] SAT_POS   = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] SAT_NEG   = -SW'(64'sd2147483648);
    localparam logic signed [DW:0]   OLIM_POS  = (DW+1)'(OUTPUT_LIMIT);
    localparam logic signed [DW:0]   OLIM_NEG  = -(DW+1)'(OUTPUT_LIMIT);

    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] acc_next;
    logic signed [DW-1:0] drive_reg;
    logic signed [DW-1:0] drive_next;

    logic signed [SW-1:0] total;
    logic signed [SW-1:0] scaled;
    logic signed [DW-1:0] sat;
    logic signed [DW:0]   acc_sum;
    logic signed [DW:0]   acc_clamped;

    always_comb
    begin
        total = {{2{prods.p_p[PW-1]}}, prods.p_p}
              + {{2{prods.p_i[PW-1]}}, prods.p_i}
              + {{2{prods.p_d[PW-1]}}, prods.p_d};
        // bias negatives so the shift truncates toward zero
        if (total[SW-1])
        begin
            scaled = (total + FRAC_BIAS) >>> GAIN_FRAC_BITS;
        end
        else
        begin
            scaled = total >>> GAIN_FRAC_BITS;
        end
        if (scaled > SAT_POS)
        begin
            sat = SAT_POS[DW-1:0];
        end
        else if (scaled < SAT_NEG)
        begin
            sat = SAT_NEG[DW-1:0];
        end
        else
        begin
            sat = scaled[DW-1:0];
        end

        acc_sum = {{(DW+1-AW){acc_reg[AW-1]}}, acc_reg} + {sat[DW-1], sat};
        if (acc_sum > OLIM_POS)
        begin
            acc_clamped = OLIM_POS;
        end
        else if (acc_sum < OLIM_NEG)
        begin
            acc_clamped = OLIM_NEG;
        end
        else
        begin
            acc_clamped = acc_sum;
        end
        acc_next = acc_clamped[AW-1:0];

        if (prods.mode == pidpi_pkg::MODE_POSITIONAL)
        begin
            drive_next = sat;
        end
        else
        begin
            drive_next = acc_clamped[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (load && prods.mode == pidpi_pkg::MODE_INCREMENTAL)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg <= drive_next;
        end
    end

    assign drive = drive_reg;

endmodule

### sv/pid_position_and_increment_top.sv
// Drive is registered: the operand register loads at the accepting edge, then the product
// and output registers load in turn as the item moves on.
// Throughput: one item per cycle while out_stall does not back up the pipeline; the
// error/integral update and the output accumulator each close their loop within one stage.
// Reset (rst_n low, asynchronous): all gains, setpoint, mode, integral, error history and
// accumulated output clear to zero; the pipeline empties.
`include "pid_position_and_increment_top_macros.svh"

module pid_position_and_increment_top #(
    parameter int INTEGRAL_LIMIT = 4000,
    parameter int OUTPUT_LIMIT   = 16384,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [pidpi_pkg::DATA_W-1:0]   measured,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [pidpi_pkg::DRIVE_W-1:0]  drive,
    input  logic                                  cfg_write,
    input  logic [pidpi_pkg::IDX_W-1:0]           cfg_index,
    input  logic [pidpi_pkg::DATA_W-1:0]          cfg_data
);

    pidpi_pkg::cfg_t   cfg_reg;
    pidpi_pkg::adv_t   adv;
    pidpi_pkg::ops_t   ops;
    pidpi_pkg::prods_t prods;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s2_free;
    logic s1_free;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pidpi_pkg::REG_MODE:     cfg_reg.mode     <= pidpi_pkg::mode_t'(cfg_data[0]);
                pidpi_pkg::REG_KP:       cfg_reg.kp       <= cfg_data;
                pidpi_pkg::REG_KI:       cfg_reg.ki       <= cfg_data;
                pidpi_pkg::REG_KD:       cfg_reg.kd       <= cfg_data;
                pidpi_pkg::REG_SETPOINT: cfg_reg.setpoint <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // a stage takes a new item when it is empty or its item moves on
    assign out_free = !out_valid_reg || !out_stall;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_stall = !s1_free;
    assign accept   = in_valid && s1_free;

    always_comb
    begin
        adv.s1_load  = accept;
        adv.s2_load  = s1_valid_reg && s2_free;
        adv.out_load = s2_valid_reg && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    pidpi_front #(
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv.s1_load),
        .measured (measured),
        .cfg      (cfg_reg),
        .ops      (ops)
    );

    pidpi_mult u_mult (
        .clk   (clk),
        .load  (adv.s2_load),
        .cfg   (cfg_reg),
        .ops   (ops),
        .prods (prods)
    );

    pidpi_back #(
        .OUTPUT_LIMIT   (OUTPUT_LIMIT),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (adv.out_load),
        .prods (prods),
        .drive (drive)
    );

    assign out_valid = out_valid_reg;

    `PIDPI_ASSERT_SAME(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_reg && s2_valid_reg)
    `PIDPI_ASSERT_NEXT(a_accept_lands, clk, rst_n, accept, s1_valid_reg)
    `PIDPI_ASSERT_NEXT(a_mid_item_kept, clk, rst_n, s2_valid_reg && !out_free, s2_valid_reg)
    `PIDPI_ASSERT_NEXT(a_no_repeat, clk, rst_n,
        out_valid_reg && !out_stall && !s2_valid_reg, !out_valid_reg)

endmodule

### tb/pid_position_and_increment_top_test.sv
`timescale 1ns / 1ps

module pid_position_and_increment_top_test;

    localparam int DATA_W         = pidpi_pkg::DATA_W;
    localparam int IDX_W          = pidpi_pkg::IDX_W;
    localparam int DRIVE_W        = pidpi_pkg::DRIVE_W;
    localparam int INTEGRAL_LIMIT = 4000;
    localparam int OUTPUT_LIMIT   = 16384;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int LATENCY        = 3;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SEGMENTS       = 6;
    localparam int SEGMENT_ITEMS  = 97;
    localparam int HOLD_CYCLES    = 80;

    localparam logic [DATA_W-1:0] WORD_MAX = 16'h7FFF;
    localparam logic [DATA_W-1:0] WORD_MIN = 16'h8000;
    localparam logic [DATA_W-1:0] UNITY    = 16'h0100;
    localparam logic [IDX_W-1:0]  FIRST_SPARE_INDEX = 3'd5;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic signed [DATA_W-1:0]   measured  = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [DRIVE_W-1:0]  drive;
    logic                       cfg_write = 1'b0;
    logic [IDX_W-1:0]           cfg_index = '0;
    logic [DATA_W-1:0]          cfg_data  = '0;

    // controller copy: settings and loop state
    pidpi_pkg::mode_t ctl_mode = pidpi_pkg::MODE_POSITIONAL;
    longint gain_p    = 0;
    longint gain_i    = 0;
    longint gain_d    = 0;
    longint target    = 0;
    longint integ_sum = 0;
    longint last_err  = 0;
    longint prior_err = 0;
    longint accum_out = 0;

    logic signed [DRIVE_W-1:0] drive_expected[$];
    int fault_count   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 37;
    int recv_idle_pct = 49;
    int hold_left     = 0;

    pid_position_and_increment_top #(
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
        .OUTPUT_LIMIT   (OUTPUT_LIMIT),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .measured  (measured),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("pid_position_and_increment_top_test failed");
            $finish;
        end
    end

    // receiver: a requested hold-off wins over random stalling
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        logic signed [DRIVE_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_expected.size() == 0)
            begin
                $display("%0t: drive %0d with no item outstanding", $time, drive);
                fault_count++;
            end
            else
            begin
                want = drive_expected.pop_front();
                if (drive !== want)
                begin
                    $display("%0t: drive mismatch: expected %0d, got %0d", $time, want, drive);
                    fault_count++;
                end
            end
        end
    end

    function automatic longint clamp_to(input longint x, input longint lo, input longint hi);
        if (x > hi)
            return hi;
        if (x < lo)
            return lo;
        return x;
    endfunction

    // drop the fraction bits toward zero, then saturate to 32 bits
    function automatic longint scale_sat(input longint acc);
        longint unit;
        unit = longint'(1) << GAIN_FRAC_BITS;
        return clamp_to(acc / unit, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic logic signed [DRIVE_W-1:0] predict_drive(
        input logic signed [DATA_W-1:0] meas
    );
        longint err;
        longint sum;
        err = target - longint'(meas);
        if (ctl_mode == pidpi_pkg::MODE_POSITIONAL)
        begin
            integ_sum = clamp_to(integ_sum + err, -INTEGRAL_LIMIT, INTEGRAL_LIMIT);
            sum = gain_p * err + gain_i * integ_sum + gain_d * (err - last_err);
            last_err = err;
            return DRIVE_W'(scale_sat(sum));
        end
        sum = gain_p * (err - last_err) + gain_i * err
            + gain_d * (err - 2 * last_err + prior_err);
        prior_err = last_err;
        last_err = err;
        accum_out = clamp_to(accum_out + scale_sat(sum), -OUTPUT_LIMIT, OUTPUT_LIMIT);
        return DRIVE_W'(accum_out);
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(7))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2, 3: return DATA_W'(int'($urandom_range(0, 1024)) - 512);
            default: return DATA_W'($urandom());
        endcase
    endfunction

    // mix wild samples with ones near the setpoint so the integral can unwind
    function automatic logic [DATA_W-1:0] pick_measured();
        int offset;
        offset = 0;
        case ($urandom_range(3))
            0: return DATA_W'($urandom());
            1: offset = int'($urandom_range(0, 80)) - 40;
            2: return $urandom_range(1) ? WORD_MAX : WORD_MIN;
            default: offset = int'($urandom_range(0, 2000)) - 1000;
        endcase
        return target[DATA_W-1:0] + offset[DATA_W-1:0];
    endfunction

    task automatic send_sample(input logic [DATA_W-1:0] meas);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        measured <= meas;
        do @(posedge clk); while (in_stall);
        drive_expected.push_back(predict_drive(meas));
    endtask

    // hold the sender until every drive value is back and the pipeline is empty
    task automatic settle_block();
        in_valid <= 1'b0;
        while (drive_expected.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            pidpi_pkg::REG_MODE:     ctl_mode = pidpi_pkg::mode_t'(val[0]);
            pidpi_pkg::REG_KP:       gain_p   = $signed(val);
            pidpi_pkg::REG_KI:       gain_i   = $signed(val);
            pidpi_pkg::REG_KD:       gain_d   = $signed(val);
            pidpi_pkg::REG_SETPOINT: target   = $signed(val);
            default:                 ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_gains(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] i,
                               input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] sp);
        write_reg(pidpi_pkg::REG_KP, p);
        write_reg(pidpi_pkg::REG_KI, i);
        write_reg(pidpi_pkg::REG_KD, d);
        write_reg(pidpi_pkg::REG_SETPOINT, sp);
    endtask

    // all gains zero after reset: every drive is zero
    task automatic check_reset_state();
        send_sample(WORD_MIN);
        send_sample(WORD_MAX);
        send_sample('0);
    endtask

    task automatic check_positional_extremes();
        settle_block();
        write_reg(pidpi_pkg::REG_MODE, DATA_W'(pidpi_pkg::MODE_POSITIONAL));
        write_gains(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        repeat (3) send_sample(WORD_MIN);
        send_sample(WORD_MAX);
        settle_block();
        write_gains(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        repeat (3) send_sample(WORD_MAX);
        send_sample(WORD_MIN);
    endtask

    // drive the accumulator into both clamps, then step it back with unity gains
    task automatic check_incremental_clamp();
        settle_block();
        write_reg(pidpi_pkg::REG_MODE, DATA_W'(pidpi_pkg::MODE_INCREMENTAL));
        write_gains(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        repeat (2) send_sample(WORD_MIN);
        repeat (2) send_sample(WORD_MAX);
        settle_block();
        write_gains(UNITY, UNITY, UNITY, WORD_MAX);
        send_sample(16'h7FF0);
        send_sample(WORD_MAX);
    endtask

    // error history carries across a change of mode
    task automatic check_mode_switch();
        settle_block();
        write_reg(pidpi_pkg::REG_MODE, DATA_W'(pidpi_pkg::MODE_POSITIONAL));
        write_gains(16'h0080, 16'h0010, 16'hFF00, 16'h0100);
        send_sample('0);
        send_sample(16'h0040);
        settle_block();
        write_reg(pidpi_pkg::REG_MODE, DATA_W'(pidpi_pkg::MODE_INCREMENTAL));
        send_sample(16'h0200);
        send_sample(16'h0100);
    endtask

    // spare indexes change nothing; upper bits of the mode word are dropped
    task automatic check_ignored_writes();
        settle_block();
        for (int i = FIRST_SPARE_INDEX; i < (1 << IDX_W); i++)
            write_reg(i[IDX_W-1:0], 16'hFFFF);
        write_reg(pidpi_pkg::REG_MODE, 16'hFFFE);
        send_sample(16'h1234);
        send_sample(16'hEDCB);
    endtask

    task automatic run_random_traffic();
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 37;
                    recv_idle_pct = 49;
                end
                1:
                begin
                    send_idle_pct = 49;
                    recv_idle_pct = 37;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                settle_block();
                write_reg(pidpi_pkg::REG_MODE, DATA_W'($urandom()));
                write_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain());
                for (int n = 0; n < SEGMENT_ITEMS; n++)
                begin
                    // starve the output so the pipeline backs up into the input
                    if (seg == 1 && n == 10 && phase != 1)
                        hold_left = HOLD_CYCLES;
                    if (phase == 1 && seg == 3 && n == 50)
                        settle_block();
                    send_sample(pick_measured());
                end
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_reset_state();
        check_positional_extremes();
        check_incremental_clamp();
        check_mode_switch();
        check_ignored_writes();
        run_random_traffic();
        in_valid <= 1'b0;
        while (drive_expected.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (fault_count == 0)
            $display("pid_position_and_increment_top_test passed");
        else
            $display("pid_position_and_increment_top_test failed");
        $finish;
    end

endmodule
